/* src/vcsd_pkg.sv */
// Shared types and constants for the vehicle CAN signal decoder.
package vcsd_pkg;

  localparam int unsigned ID_W   = 29;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned VAL_W  = 17;
  localparam int unsigned KM_W   = 32;

  typedef enum logic [2:0] {
    KIND_UNKNOWN = 3'd0,
    KIND_WHEEL   = 3'd1,
    KIND_LAMPS   = 3'd2,
    KIND_PEDALS  = 3'd3,
    KIND_TEMPS   = 3'd4,
    KIND_MAPV    = 3'd5,
    KIND_MAPH    = 3'd6,
    KIND_ODO     = 3'd7
  } frame_kind_t;

  localparam logic [ID_W-1:0] ID_WHEEL  = 29'h018;
  localparam logic [ID_W-1:0] ID_LAMPS  = 29'h020;
  localparam logic [ID_W-1:0] ID_PEDALS = 29'h080;
  localparam logic [ID_W-1:0] ID_TEMPS  = 29'h100;
  localparam logic [ID_W-1:0] ID_MAPV   = 29'h150;
  localparam logic [ID_W-1:0] ID_MAPH   = 29'h160;
  localparam logic [ID_W-1:0] ID_ODO    = 29'h300;

  // lamp codes that update the flags
  localparam logic [3:0] LAMP_OFF         = 4'd0;
  localparam logic [3:0] LAMP_BRAKE       = 4'd1;
  localparam logic [3:0] LAMP_LEFT        = 4'd4;
  localparam logic [3:0] LAMP_LEFT_BRAKE  = 4'd5;
  localparam logic [3:0] LAMP_RIGHT       = 4'd8;
  localparam logic [3:0] LAMP_RIGHT_BRAKE = 4'd9;

  localparam logic [VAL_W-1:0] KEY_SUM     = 17'd522;
  localparam logic [VAL_W-1:0] TEMP_OFFSET = 17'd40;
  localparam logic [7:0]       NIBBLE_MASK = 8'h0f;

  // raw*1500/6213 as raw*ceil(1500*2^24/6213) >> 24, exact for 12-bit raw
  localparam int unsigned      SPEED_SHIFT = 24;
  localparam logic [21:0]      SPEED_RECIP = 22'd4050511;
  localparam logic [VAL_W-1:0] SPEED_MAX   = 17'd988;

  // x/10 as x*205 >> 11, exact below 1029
  localparam logic [7:0] TENTH_RECIP = 8'd205;

  typedef struct packed {
    logic left;
    logic right;
    logic brake;
    logic key;
  } lamp_flags_t;

endpackage

/* src/vehicle_can_signal_decoder.sv */
// Top level: decodes received CAN frames into scaled vehicle signals.
//
// Input stream (in_*): one CAN frame per transaction, identifier and eight
// payload bytes. Output stream (out_*): exactly one result per frame, in
// order, carrying the frame kind, three kind-specific values, the held lamp
// and key flags and the running kilometre total as they stand after the frame.
//
// A frame is registered in the input register on acceptance, decoded by one
// pass of shallow logic (byte selects, a constant multiply for the speed
// scaling, small adds) and moves into the output register, which drives
// out_tvalid, when that stage can advance; one frame per cycle is sustained
// while out_tready stays high. The two registers form a two-deep pipeline,
// so a frame is still taken while a finished result waits to be taken.
//
// When the receiver stalls, the result holds in the output register, the next
// frame waits in the input register, and in_tready drops once both are full.
// Held flags and the total change only as a frame moves into the output
// register, so stalling never repeats or loses an update.
//
// Synchronous active-low reset empties both stages and clears the lamp and key
// flags, the last odometer byte, the last trip and the kilometre total.
module vehicle_can_signal_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // frame_id[28:0], frame_data[92:29], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // value_a[16:0], value_b[33:17], value_c[50:34],
                                  // left_lamp[51], right_lamp[52], brake_lamp[53],
                                  // key_present[54], total_km[86:55], zero pad
  output logic [7:0]  out_tuser   // frame_kind[2:0], zero pad
);
  import vcsd_pkg::*;

  // input stage
  logic              s1_valid_r;
  logic [ID_W-1:0]   s1_id_r;
  logic [DATA_W-1:0] s1_data_r;

  // output stage
  logic              out_valid_r;
  frame_kind_t       out_kind_r;
  logic [VAL_W-1:0]  out_a_r, out_b_r, out_c_r;

  // held state
  lamp_flags_t       flags_r, flags_nxt;
  logic [7:0]        odo_last_r, odo_last_nxt;
  logic [7:0]        trip_last_r, trip_last_nxt;
  logic [KM_W-1:0]   km_total_r, km_total_nxt;

  logic              adv;
  logic              s1_take;

  frame_kind_t       kind_nxt;
  logic [VAL_W-1:0]  a_nxt, b_nxt, c_nxt;

  logic [7:0]        d [8];
  logic [11:0]       speed_raw;
  logic [33:0]       speed_prod;
  logic [15:0]       fuel_prod;
  logic [3:0]        lamp_code;
  logic [VAL_W-1:0]  key_sum;

  assign adv       = !out_valid_r || out_tready;
  assign s1_take   = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_id_r   <= in_tdata[28:0];
      s1_data_r <= in_tdata[92:29];
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      d[i] = s1_data_r[8*i +: 8];
    end
  end

  assign speed_raw  = {d[4][3:0], d[5]};
  assign speed_prod = {22'd0, speed_raw} * {12'd0, SPEED_RECIP};
  assign fuel_prod  = {8'd0, d[6]} * {8'd0, TENTH_RECIP};
  assign lamp_code  = d[1][7:4];
  assign key_sum    = {9'd0, d[3]} + {9'd0, d[4]} + {9'd0, d[5]};

  always_comb begin
    kind_nxt      = KIND_UNKNOWN;
    a_nxt         = '0;
    b_nxt         = '0;
    c_nxt         = '0;
    flags_nxt     = flags_r;
    odo_last_nxt  = odo_last_r;
    trip_last_nxt = trip_last_r;
    km_total_nxt  = km_total_r;
    priority if (s1_id_r == ID_WHEEL) begin
      kind_nxt = KIND_WHEEL;
      a_nxt    = {14'd0, d[4][7:5]};
      b_nxt    = {7'd0, speed_prod[SPEED_SHIFT +: 10]};
      c_nxt    = {12'd0, fuel_prod[15:11]};
    end else if (s1_id_r == ID_LAMPS) begin
      kind_nxt = KIND_LAMPS;
      a_nxt    = key_sum;
      b_nxt    = {13'd0, lamp_code};
      unique case (lamp_code)
        LAMP_OFF:         {flags_nxt.left, flags_nxt.brake, flags_nxt.right} = 3'b000;
        LAMP_BRAKE:       {flags_nxt.left, flags_nxt.brake, flags_nxt.right} = 3'b010;
        LAMP_LEFT:        {flags_nxt.left, flags_nxt.brake, flags_nxt.right} = 3'b100;
        LAMP_LEFT_BRAKE:  {flags_nxt.left, flags_nxt.brake, flags_nxt.right} = 3'b110;
        LAMP_RIGHT:       {flags_nxt.left, flags_nxt.brake, flags_nxt.right} = 3'b001;
        LAMP_RIGHT_BRAKE: {flags_nxt.left, flags_nxt.brake, flags_nxt.right} = 3'b011;
        default: ;
      endcase
      flags_nxt.key = (key_sum == KEY_SUM);
    end else if (s1_id_r == ID_PEDALS) begin
      kind_nxt = KIND_PEDALS;
      a_nxt    = {10'd0, d[1][7:1]};
      b_nxt    = {10'd0, d[0][7:1]};
      c_nxt    = {1'b0, d[5], d[6]};
    end else if (s1_id_r == ID_TEMPS) begin
      kind_nxt = KIND_TEMPS;
      a_nxt    = {9'd0, d[3]} - TEMP_OFFSET;
      b_nxt    = {9'd0, d[4]};
      c_nxt    = {9'd0, d[5]} - TEMP_OFFSET;
    end else if (s1_id_r == ID_MAPV) begin
      kind_nxt = KIND_MAPV;
      a_nxt    = {1'b0, d[6] & NIBBLE_MASK, d[7]};
      b_nxt    = {9'd0, d[1]};
      c_nxt    = {9'd0, d[2]};
    end else if (s1_id_r == ID_MAPH) begin
      kind_nxt = KIND_MAPH;
      a_nxt    = {1'b0, d[6] & NIBBLE_MASK, d[7]};
    end else if (s1_id_r == ID_ODO) begin
      kind_nxt = KIND_ODO;
      // a wrapped odometer byte keeps the previous trip
      if (d[5] >= odo_last_r) begin
        trip_last_nxt = d[5] - odo_last_r;
      end
      odo_last_nxt = d[5];
      km_total_nxt = km_total_r + {24'd0, trip_last_nxt};
      a_nxt        = {10'd0, d[3][7:1]};
      b_nxt        = {13'd0, d[6][7:4]};
      c_nxt        = {9'd0, trip_last_nxt};
    end else begin
      kind_nxt = KIND_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      flags_r     <= '0;
      odo_last_r  <= '0;
      trip_last_r <= '0;
      km_total_r  <= '0;
    end else begin
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_take) begin
        flags_r     <= flags_nxt;
        odo_last_r  <= odo_last_nxt;
        trip_last_r <= trip_last_nxt;
        km_total_r  <= km_total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      out_kind_r <= kind_nxt;
      out_a_r    <= a_nxt;
      out_b_r    <= b_nxt;
      out_c_r    <= c_nxt;
    end
  end

  // flags and total in the output register are the held state after its frame
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, km_total_r, flags_r.key, flags_r.brake, flags_r.right,
                       flags_r.left, out_c_r, out_b_r, out_a_r};
  assign out_tuser  = {5'd0, out_kind_r};

  // total moves only when an odometer frame enters the output register
  assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_take && kind_nxt == KIND_ODO) |=> $stable(km_total_r))
    else $error("kilometre total changed without an odometer transaction");

  // unknown frames carry zero values
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2:0] == KIND_UNKNOWN) |->
      (out_tdata[50:0] == 51'd0))
    else $error("unknown frame with non-zero values");

  // key flag of a lamp/key result matches its own byte sum
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2:0] == KIND_LAMPS) |->
      (out_tdata[54] == (out_tdata[16:0] == KEY_SUM)))
    else $error("key flag does not match key byte sum");

  // scaled speed never exceeds the value for full-scale raw input
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2:0] == KIND_WHEEL) |-> (out_tdata[33:17] <= SPEED_MAX))
    else $error("speed out of range");

  // input side stalls only with both stages full and the receiver stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_tvalid && !out_tready))
    else $error("input stalled with room in the pipeline");

endmodule
